[design/hcbd_pkg.sv]
package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEFAULT = 32;
  localparam int unsigned HEX_BITS = 4;
  localparam int unsigned LINE_BITS = 16;
  localparam logic [LINE_BITS-1:0] LINE_LIMIT_RESET = 16'd1024;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_BODY  = 2'd1;
  localparam logic [1:0] KIND_TAIL  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD       = 2'd1;
  localparam logic [1:0] STAT_AFTER_ERR = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [HEX_BITS-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = HEX_BITS'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = HEX_BITS'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = HEX_BITS'(c - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

[design/http_chunked_body_decoder_unit.sv]
// Chunked transfer decoder: one byte of an HTTP/1.1 chunked message body per item.
// Input channel: in_valid_i, in_stall_o, in_byte_i. Output channel: out_valid_o,
// out_stall_i and the result fields out_byte_o, out_kind_o, status_o, done_res_o.
// Every input item yields exactly one result item, in order.
// An accepted item is held in an input register; once the output register is free,
// its result is written into the output register, which drives the outputs. One
// item is accepted every cycle when the receiver does not stall; throughput is one
// byte per clock.
// When the receiver stalls, the held result stays on the outputs and the input
// register still takes one more item; only when both registers are full is
// in_stall_o raised, combinationally from out_stall_i.
// The line limit is written through cfg_we_i and cfg_wdata_i; the user must do so
// only while idle, as the block does not enforce it. Reset empties both registers,
// sets the limit to 1024 and returns the decoder to the start of a chunk header. An
// error latches until reset; later bytes return the after-error status.
module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic [1:0]           out_kind_o,
  output logic [1:0]           status_o,
  output logic                 done_res_o,
  input  logic                 cfg_we_i,
  input  logic [LINE_BITS-1:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    PH_HDR_START,
    PH_HDR_LEADCR,
    PH_HDR_NUM,
    PH_HDR_EXT,
    PH_HDR_CR,
    PH_BODY,
    PH_TRL_LINE,
    PH_TRL_CR,
    PH_DONE,
    PH_ERROR
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] remaining_q, remaining_d;
  logic [LINE_BITS-1:0] line_count_q, line_count_d;
  logic                 saw_digit_q, saw_digit_d;
  logic                 line_nonempty_q, line_nonempty_d;
  logic                 stalled_q, stalled_d;
  logic [LINE_BITS-1:0] max_line_q;

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;

  logic                 out_valid_q;
  logic [7:0]           out_byte_q, out_byte_d;
  logic [1:0]           out_kind_q, out_kind_d;
  logic [1:0]           status_q, status_d;
  logic                 done_q, done_d;

  logic                 out_free;
  logic                 advance;
  logic                 in_accept;
  hex_digit_t           hex;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign hex        = hex_decode(s1_byte_q);

  always_comb begin
    logic complete;
    logic bad;
    logic num_path;
    complete        = 1'b0;
    bad             = 1'b0;
    num_path        = 1'b0;
    phase_d         = phase_q;
    remaining_d     = remaining_q;
    line_count_d    = line_count_q;
    saw_digit_d     = saw_digit_q;
    line_nonempty_d = line_nonempty_q;
    stalled_d       = stalled_q;
    out_byte_d      = '0;
    out_kind_d      = KIND_FRAME;
    status_d        = STAT_OK;
    done_d          = 1'b0;

    priority if (phase_q == PH_ERROR) begin
      status_d = STAT_AFTER_ERR;
    end else if (phase_q == PH_DONE) begin
      out_byte_d = s1_byte_q;
      out_kind_d = KIND_TAIL;
      done_d     = 1'b1;
    end else if (phase_q == PH_BODY) begin
      out_byte_d  = s1_byte_q;
      out_kind_d  = KIND_BODY;
      remaining_d = remaining_q - SIZE_BITS'(1);
      if (remaining_d == '0) begin
        phase_d         = PH_HDR_START;
        line_count_d    = '0;
        saw_digit_d     = 1'b0;
        line_nonempty_d = 1'b0;
        stalled_d       = 1'b0;
      end
    end else begin
      if (!stalled_q) begin
        unique case (phase_q)
          PH_HDR_START: begin
            if (s1_byte_q == CHAR_CR) begin
              phase_d = PH_HDR_LEADCR;
            end else begin
              num_path = 1'b1;
            end
          end
          PH_HDR_NUM: num_path = 1'b1;
          PH_HDR_LEADCR: begin
            if (s1_byte_q == CHAR_LF) begin
              phase_d = PH_HDR_NUM;
            end else begin
              bad = 1'b1;
            end
          end
          PH_HDR_EXT: begin
            if (s1_byte_q == CHAR_CR) begin
              phase_d = PH_HDR_CR;
            end
          end
          PH_HDR_CR: begin
            if (s1_byte_q == CHAR_LF) begin
              complete        = 1'b1;
              line_count_d    = '0;
              line_nonempty_d = 1'b0;
              stalled_d       = 1'b0;
              saw_digit_d     = 1'b0;
              phase_d         = (remaining_q == '0) ? PH_TRL_LINE : PH_BODY;
            end else begin
              stalled_d = 1'b1;
            end
          end
          PH_TRL_LINE: begin
            if (s1_byte_q == CHAR_CR) begin
              phase_d = PH_TRL_CR;
            end else begin
              line_nonempty_d = 1'b1;
            end
          end
          PH_TRL_CR: begin
            if (s1_byte_q == CHAR_LF) begin
              complete = 1'b1;
              if (line_nonempty_q) begin
                line_count_d    = '0;
                line_nonempty_d = 1'b0;
                stalled_d       = 1'b0;
                phase_d         = PH_TRL_LINE;
              end else begin
                phase_d = PH_DONE;
                done_d  = 1'b1;
              end
            end else begin
              stalled_d = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (num_path) begin
          if (hex.valid) begin
            if (remaining_q[SIZE_BITS-1 -: HEX_BITS] != '0) begin
              bad = 1'b1;
            end else begin
              remaining_d = {remaining_q[SIZE_BITS-HEX_BITS-1:0], hex.value};
              saw_digit_d = 1'b1;
              phase_d     = PH_HDR_NUM;
            end
          end else if (!saw_digit_q) begin
            bad = 1'b1;
          end else if (s1_byte_q == CHAR_CR) begin
            phase_d = PH_HDR_CR;
          end else begin
            phase_d = PH_HDR_EXT;
          end
        end
      end

      if (!bad && !complete) begin
        if (line_count_q >= max_line_q) begin
          bad = 1'b1;
        end else begin
          line_count_d = line_count_q + LINE_BITS'(1);
        end
      end
      if (bad) begin
        phase_d  = PH_ERROR;
        status_d = STAT_BAD;
        done_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HDR_START;
      remaining_q     <= '0;
      line_count_q    <= '0;
      saw_digit_q     <= 1'b0;
      line_nonempty_q <= 1'b0;
      stalled_q       <= 1'b0;
      max_line_q      <= LINE_LIMIT_RESET;
      s1_valid_q      <= 1'b0;
      s1_byte_q       <= '0;
      out_valid_q     <= 1'b0;
      out_byte_q      <= '0;
      out_kind_q      <= KIND_FRAME;
      status_q        <= STAT_OK;
      done_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_line_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        s1_byte_q <= in_byte_i;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q         <= phase_d;
        remaining_q     <= remaining_d;
        line_count_q    <= line_count_d;
        saw_digit_q     <= saw_digit_d;
        line_nonempty_q <= line_nonempty_d;
        stalled_q       <= stalled_d;
        out_byte_q      <= out_byte_d;
        out_kind_q      <= out_kind_d;
        status_q        <= status_d;
        done_q          <= done_d;
        out_valid_q     <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign status_o    = status_q;
  assign done_res_o  = done_q;

  // An error holds until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("error phase was left");

  // The body phase always has bytes left to count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> remaining_q != '0)
    else $error("body phase with zero remaining");

  // A held input item is kept while the output register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held input item lost");

  // Done is only reported on an ok result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> status_q == STAT_OK)
    else $error("done reported with error status");

endmodule
